/* hw/rtl/fbc_pkg.sv */
package fbc_pkg;

  localparam int unsigned W  = 32;
  localparam int unsigned PW = 64;
  localparam int unsigned SW = 68;

  localparam logic [30:0] SD_RESET = 31'd65536000;

  // proj entries whose depth terms a build rebuilds
  localparam logic [3:0] P_IDX_Z = 4'd10;
  localparam logic [3:0] P_IDX_W = 4'd14;

  localparam logic [1:0] COL_X = 2'd0;
  localparam logic [1:0] COL_Y = 2'd1;
  localparam logic [1:0] COL_Z = 2'd2;
  localparam logic [1:0] COL_W = 2'd3;

  localparam logic [2:0] PLANE_NEAR   = 3'd0;
  localparam logic [2:0] PLANE_FAR    = 3'd1;
  localparam logic [2:0] PLANE_LEFT   = 3'd2;
  localparam logic [2:0] PLANE_RIGHT  = 3'd3;
  localparam logic [2:0] PLANE_TOP    = 3'd4;
  localparam logic [2:0] PLANE_BOTTOM = 3'd5;

  typedef enum logic [1:0] {
    KIND_VIEW  = 2'd0,
    KIND_PROJ  = 2'd1,
    KIND_BUILD = 2'd2,
    KIND_TEST  = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_WRITE,
    OP_CAPT,
    OP_DIVZ,
    OP_DIVR,
    OP_P14,
    OP_SQRT,
    OP_DIVP,
    OP_RESULT
  } op_e;

  typedef enum logic [2:0] {
    ISS_NONE,
    ISS_MM,
    ISS_PC,
    ISS_SQ,
    ISS_RZ,
    ISS_TEST
  } iss_e;

  typedef struct packed {
    logic       accept;
    op_e        op;
    iss_e       iss;
    logic [3:0] vaddr;
    logic [3:0] paddr;
    logic [3:0] maddr;
    logic       povr;
    logic [3:0] mm_idx;
    logic       first;
    logic       last;
    logic       second;
    logic [2:0] plane;
    logic [1:0] k;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic sqrt_done;
  } sts_t;

  function automatic logic [1:0] sel_col(input logic [2:0] plane);
    logic [1:0] c;
    case (plane)
      PLANE_NEAR, PLANE_FAR:   c = COL_Z;
      PLANE_LEFT, PLANE_RIGHT: c = COL_X;
      default:                 c = COL_Y;
    endcase
    return c;
  endfunction

  function automatic logic sel_neg(input logic [2:0] plane);
    logic n;
    case (plane)
      PLANE_FAR, PLANE_RIGHT, PLANE_TOP: n = 1'b1;
      default:                           n = 1'b0;
    endcase
    return n;
  endfunction

  // {hit, value}: clamp to signed 32 bits
  function automatic logic [W:0] sat32(input logic signed [SW-1:0] x);
    logic signed [SW-1:0] hi;
    logic signed [SW-1:0] lo;
    logic [W:0]           r;
    hi = {{(SW-W){1'b0}}, 32'h7fff_ffff};
    lo = {{(SW-W){1'b1}}, 32'h8000_0000};
    if (x > hi) begin
      r = {1'b1, 32'h7fff_ffff};
    end else if (x < lo) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, x[W-1:0]};
    end
    return r;
  endfunction

endpackage

/* hw/rtl/fbc_div.sv */
module fbc_div
  import fbc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [PW-1:0] num_i,
  input  logic signed [PW-1:0] den_i,
  output logic                 done_o,
  output logic [W-1:0]         quo_o,
  output logic                 hit_o
);

  logic          busy_q;
  logic [5:0]    cnt_q;
  logic [PW:0]   rem_q;
  logic [PW-1:0] quo_q;
  logic [PW-1:0] dmag_q;
  logic          neg_q;
  logic [W-1:0]  res_q;
  logic          hit_q;
  logic          done_q;

  logic [PW:0]   rem_s;
  logic          ge;
  logic [PW:0]   rem_n;
  logic [PW-1:0] quo_n;
  logic [W-1:0]  fin_val;
  logic          fin_hit;

  always_comb begin
    rem_s = {rem_q[PW-1:0], quo_q[PW-1]};
    ge    = rem_s >= {1'b0, dmag_q};
    rem_n = ge ? rem_s - {1'b0, dmag_q} : rem_s;
    quo_n = {quo_q[PW-2:0], ge};
    // clamp the signed quotient
    if (neg_q) begin
      if (quo_n > {{(PW-W){1'b0}}, 32'h8000_0000}) begin
        fin_val = 32'h8000_0000;
        fin_hit = 1'b1;
      end else begin
        fin_val = ~quo_n[W-1:0] + 32'd1;
        fin_hit = 1'b0;
      end
    end else begin
      if (quo_n[PW-1:W-1] != '0) begin
        fin_val = 32'h7fff_ffff;
        fin_hit = 1'b1;
      end else begin
        fin_val = quo_n[W-1:0];
        fin_hit = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        if (den_i == '0) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          cnt_q  <= '0;
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      quo_q  <= num_i[PW-1] ? -num_i : num_i;
      dmag_q <= den_i[PW-1] ? -den_i : den_i;
      neg_q  <= num_i[PW-1] ^ den_i[PW-1];
      if (den_i == '0) begin
        hit_q <= 1'b1;
        if (num_i > 0) begin
          res_q <= 32'h7fff_ffff;
        end else if (num_i < 0) begin
          res_q <= 32'h8000_0000;
        end else begin
          res_q <= '0;
        end
      end
    end else if (busy_q) begin
      rem_q <= rem_n;
      quo_q <= quo_n;
      if (cnt_q == 6'd63) begin
        res_q <= fin_val;
        hit_q <= fin_hit;
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = res_q;
  assign hit_o  = hit_q;

endmodule

/* hw/rtl/fbc_sqrt.sv */
module fbc_sqrt
  import fbc_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [PW-1:0] n_i,
  output logic          done_o,
  output logic [W-1:0]  root_o
);

  logic          busy_q;
  logic          done_q;
  logic [4:0]    cnt_q;
  logic [PW-1:0] n_q;
  logic [W+1:0]  rem_q;
  logic [W-1:0]  root_q;

  logic [W+1:0]  rem_s;
  logic [W+1:0]  trial;
  logic          ge;

  always_comb begin
    rem_s = {rem_q[W-1:0], n_q[PW-1:PW-2]};
    trial = {root_q, 2'b01};
    ge    = rem_s >= trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q    <= n_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      n_q    <= {n_q[PW-3:0], 2'b00};
      rem_q  <= ge ? rem_s - trial : rem_s;
      root_q <= {root_q[W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

/* hw/rtl/fbc_dp.sv */
module fbc_dp
  import fbc_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  input  logic [30:0]         sd_i,
  input  logic [1:0]          kind_i,
  input  logic [1:0]          row_i,
  input  logic [1:0]          col_i,
  input  logic signed [W-1:0] value_i,
  input  logic signed [W-1:0] min_x_i,
  input  logic signed [W-1:0] min_y_i,
  input  logic signed [W-1:0] min_z_i,
  input  logic signed [W-1:0] max_x_i,
  input  logic signed [W-1:0] max_y_i,
  input  logic signed [W-1:0] max_z_i,
  output logic                visible_o,
  output logic                degenerate_o
);

  typedef enum logic [1:0] {
    DT_ZMIN,
    DT_R,
    DT_PLANE
  } dtgt_e;

  // latched item
  kind_e               kind_q;
  logic [3:0]          idx_q;
  logic signed [W-1:0] val_q;
  logic signed [W-1:0] bmin_q [3];
  logic signed [W-1:0] bmax_q [3];

  logic signed [W-1:0] view_mem [16];
  logic signed [W-1:0] proj_mem [16];
  logic signed [W-1:0] m_mem    [16];
  logic signed [W-1:0] vrd_q, prd_q, mrd_q;

  logic signed [W-1:0] tmp_q, zmin_q, r_q, p14_q, hold_q;
  logic signed [W-1:0] comp_q [4];
  logic [PW-1:0]       len2_q;
  logic [W-1:0]        len_q;
  logic signed [PW-1:0] acc_q;
  logic [3:0][W-1:0]   plane_q [6];
  logic                deg_q, cull_q;
  logic                vis_o_q, deg_o_q;

  // pipeline tags
  logic       mm_v1, pc_v1, mm_v2, sq_v2, t_v2, vb_q;
  logic [3:0] paddr1, idx1, idx2;
  logic       povr1, first1, last1, first2, last2, sec1, neg1, sqf2;
  logic [1:0] k1;

  logic signed [PW-1:0] prod0_q, t1_q, t2_q, d_q;
  logic signed [PW+1:0] s01_q, s23_q, ssum;

  dtgt_e      dtgt_q;
  logic [2:0] dpl_q;
  logic [1:0] dk_q;

  logic signed [W-1:0]  p_eff, mul_a, mul_b;
  logic [3:0][W-1:0]    crow;
  logic signed [W-1:0]  ca, cb, cc, cd, xs, ys, zs;
  logic signed [PW-1:0] term, acc_n;
  logic [W:0]           sat_mm, sat_pc, sat_p14;
  logic signed [W+1:0]  pc_b, pc_sum;
  logic signed [PW+1:0] negp;
  logic                 div_start;
  logic signed [PW-1:0] div_num, div_den;
  logic signed [W:0]    neg_tmp;
  logic                 div_done, div_hit, sq_done;
  logic [W-1:0]         div_quo, sq_root;
  logic                 any_hit;

  fbc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .hit_o   (div_hit)
  );

  fbc_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.op == OP_SQRT),
    .n_i     (len2_q),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  assign sts_o.div_done  = div_done;
  assign sts_o.sqrt_done = sq_done;

  always_comb begin
    // working copy of proj with rebuilt depth terms
    p_eff = prd_q;
    if (povr1 && paddr1 == P_IDX_Z) begin
      p_eff = r_q;
    end else if (povr1 && paddr1 == P_IDX_W) begin
      p_eff = p14_q;
    end

    crow = plane_q[cmd_i.plane];
    ca = $signed(crow[0]);
    cb = $signed(crow[1]);
    cc = $signed(crow[2]);
    cd = $signed(crow[3]);
    // per axis, the corner that maximises the plane's dot product
    xs = ca[W-1] ? bmin_q[0] : bmax_q[0];
    ys = cb[W-1] ? bmin_q[1] : bmax_q[1];
    zs = cc[W-1] ? bmin_q[2] : bmax_q[2];

    mul_a = '0;
    mul_b = '0;
    if (mm_v1) begin
      mul_a = vrd_q;
      mul_b = p_eff;
    end else begin
      case (cmd_i.iss)
        ISS_SQ: begin
          mul_a = comp_q[cmd_i.k];
          mul_b = comp_q[cmd_i.k];
        end
        ISS_RZ: begin
          mul_a = r_q;
          mul_b = zmin_q;
        end
        ISS_TEST: begin
          mul_a = ca;
          mul_b = xs;
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
        end
      endcase
    end

    term   = prod0_q >>> FRAC_BITS;
    acc_n  = (first2 ? '0 : acc_q) + term;
    sat_mm = sat32({{(SW-PW){acc_n[PW-1]}}, acc_n});

    pc_b   = neg1 ? -{{2{mrd_q[W-1]}}, mrd_q} : {{2{mrd_q[W-1]}}, mrd_q};
    pc_sum = {{2{hold_q[W-1]}}, hold_q} + pc_b;
    sat_pc = sat32({{(SW-W-2){pc_sum[W+1]}}, pc_sum});

    negp    = -{{2{prod0_q[PW-1]}}, prod0_q};
    negp    = negp >>> FRAC_BITS;
    sat_p14 = sat32({{(SW-PW-2){negp[PW+1]}}, negp});

    ssum = s01_q + s23_q;

    neg_tmp   = -{tmp_q[W-1], tmp_q};
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (cmd_i.op)
      OP_DIVZ: begin
        div_start = 1'b1;
        div_num   = {{(PW-W-1){neg_tmp[W]}}, neg_tmp} <<< FRAC_BITS;
        div_den   = {{(PW-W){prd_q[W-1]}}, prd_q};
      end
      OP_DIVR: begin
        div_start = 1'b1;
        div_num   = {{(PW-31){1'b0}}, sd_i} <<< FRAC_BITS;
        div_den   = $signed({{(PW-31){1'b0}}, sd_i}) - {{(PW-W){zmin_q[W-1]}}, zmin_q};
      end
      OP_DIVP: begin
        div_start = 1'b1;
        div_num   = {{(PW-W){comp_q[cmd_i.k][W-1]}}, comp_q[cmd_i.k]} <<< FRAC_BITS;
        div_den   = {{(PW-W){1'b0}}, len_q};
      end
      default: begin
        div_start = 1'b0;
      end
    endcase

    any_hit = (mm_v2 && last2 && sat_mm[W]) || (pc_v1 && sec1 && sat_pc[W]) ||
              (cmd_i.op == OP_P14 && sat_p14[W]) || (div_done && div_hit);
  end

  // matrix stores
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_WRITE && kind_q == KIND_VIEW) begin
      view_mem[idx_q] <= val_q;
    end
    if (cmd_i.op == OP_WRITE && kind_q == KIND_PROJ) begin
      proj_mem[idx_q] <= val_q;
    end
    if (mm_v2 && last2) begin
      m_mem[idx2] <= $signed(sat_mm[W-1:0]);
    end
    vrd_q <= view_mem[cmd_i.vaddr];
    prd_q <= proj_mem[cmd_i.paddr];
    mrd_q <= m_mem[cmd_i.maddr];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q    <= kind_e'(kind_i);
      idx_q     <= {row_i, col_i};
      val_q     <= value_i;
      bmin_q[0] <= (min_x_i < max_x_i) ? min_x_i : max_x_i;
      bmax_q[0] <= (min_x_i < max_x_i) ? max_x_i : min_x_i;
      bmin_q[1] <= (min_y_i < max_y_i) ? min_y_i : max_y_i;
      bmax_q[1] <= (min_y_i < max_y_i) ? max_y_i : min_y_i;
      bmin_q[2] <= (min_z_i < max_z_i) ? min_z_i : max_z_i;
      bmax_q[2] <= (min_z_i < max_z_i) ? max_z_i : min_z_i;
    end

    paddr1 <= cmd_i.paddr;
    povr1  <= cmd_i.povr;
    idx1   <= cmd_i.mm_idx;
    first1 <= cmd_i.first;
    last1  <= cmd_i.last;
    sec1   <= cmd_i.second;
    k1     <= cmd_i.k;
    neg1   <= sel_neg(cmd_i.plane);
    idx2   <= idx1;
    first2 <= mm_v1 ? first1 : cmd_i.first;
    last2  <= last1;
    sqf2   <= cmd_i.first;

    prod0_q <= mul_a * mul_b;
    t1_q    <= cb * ys;
    t2_q    <= cc * zs;
    d_q     <= {{(PW-W){cd[W-1]}}, cd} <<< FRAC_BITS;
    s01_q   <= {{2{prod0_q[PW-1]}}, prod0_q} + {{2{t1_q[PW-1]}}, t1_q};
    s23_q   <= {{2{t2_q[PW-1]}}, t2_q} + {{2{d_q[PW-1]}}, d_q};

    if (mm_v2) begin
      acc_q <= acc_n;
    end
    if (pc_v1 && !sec1) begin
      hold_q <= mrd_q;
    end
    if (pc_v1 && sec1) begin
      comp_q[k1] <= $signed(sat_pc[W-1:0]);
    end
    if (sq_v2) begin
      len2_q <= (sqf2 ? '0 : len2_q) + prod0_q;
    end
    if (sq_done) begin
      len_q <= sq_root;
    end
    if (cmd_i.op == OP_CAPT) begin
      tmp_q <= prd_q;
    end
    if (cmd_i.op == OP_P14) begin
      p14_q <= $signed(sat_p14[W-1:0]);
    end
    if (div_start) begin
      dpl_q <= cmd_i.plane;
      dk_q  <= cmd_i.k;
      case (cmd_i.op)
        OP_DIVZ: dtgt_q <= DT_ZMIN;
        OP_DIVR: dtgt_q <= DT_R;
        default: dtgt_q <= DT_PLANE;
      endcase
    end
    if (div_done && dtgt_q == DT_ZMIN) begin
      zmin_q <= $signed(div_quo);
    end
    if (div_done && dtgt_q == DT_R) begin
      r_q <= $signed(div_quo);
    end
    if (cmd_i.op == OP_RESULT) begin
      vis_o_q <= (kind_q == KIND_TEST) && !cull_q;
      deg_o_q <= (kind_q == KIND_BUILD) && deg_q;
    end
  end

  // control state and the plane store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mm_v1  <= 1'b0;
      pc_v1  <= 1'b0;
      mm_v2  <= 1'b0;
      sq_v2  <= 1'b0;
      t_v2   <= 1'b0;
      vb_q   <= 1'b0;
      deg_q  <= 1'b0;
      cull_q <= 1'b0;
      for (int p = 0; p < 6; p++) begin
        plane_q[p] <= '0;
      end
    end else begin
      mm_v1 <= cmd_i.iss == ISS_MM;
      pc_v1 <= cmd_i.iss == ISS_PC;
      mm_v2 <= mm_v1;
      sq_v2 <= cmd_i.iss == ISS_SQ;
      t_v2  <= cmd_i.iss == ISS_TEST;
      vb_q  <= t_v2;
      if (cmd_i.accept) begin
        deg_q <= 1'b0;
      end else if (any_hit) begin
        deg_q <= 1'b1;
      end
      if (cmd_i.accept) begin
        cull_q <= 1'b0;
      end else if (vb_q && ssum[PW+1]) begin
        cull_q <= 1'b1;
      end
      if (div_done && dtgt_q == DT_PLANE) begin
        plane_q[dpl_q][dk_q] <= div_quo;
      end
    end
  end

  assign visible_o    = vis_o_q;
  assign degenerate_o = deg_o_q;

endmodule

/* hw/rtl/fbc_ctrl.sv */
module fbc_ctrl
  import fbc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_kind_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  sts_t       sts_i,
  output cmd_t       cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_WR, S_B14, S_B10, S_BZ, S_BZW, S_BR, S_BRW, S_RZ, S_P14,
    S_MM, S_MMD, S_PC, S_PCD, S_SQ, S_SQD, S_SQS, S_SQW, S_DV, S_DVW,
    S_TI, S_TD, S_FIN
  } state_e;

  state_e     state_q, state_d;
  logic [5:0] cnt_q, cnt_d;
  logic [2:0] pl_q, pl_d;
  logic [1:0] kk_q, kk_d;
  logic       out_valid_q, out_valid_d;
  logic       acc;

  always_comb begin
    acc         = in_valid_i && state_q == S_IDLE;
    state_d     = state_q;
    cnt_d       = cnt_q;
    pl_d        = pl_q;
    kk_d        = kk_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    cmd_o.op    = OP_NONE;
    cmd_o.iss   = ISS_NONE;
    cmd_o.accept = acc;

    unique case (state_q)
      S_IDLE: begin
        cnt_d = '0;
        if (acc) begin
          case (kind_e'(in_kind_i))
            KIND_BUILD: state_d = S_B14;
            KIND_TEST:  state_d = S_TI;
            default:    state_d = S_WR;
          endcase
        end
      end
      S_WR: begin
        cmd_o.op = OP_WRITE;
        state_d  = S_FIN;
      end
      S_B14: begin
        cmd_o.paddr = P_IDX_W;
        state_d     = S_B10;
      end
      S_B10: begin
        cmd_o.paddr = P_IDX_Z;
        cmd_o.op    = OP_CAPT;
        state_d     = S_BZ;
      end
      S_BZ: begin
        cmd_o.op = OP_DIVZ;
        state_d  = S_BZW;
      end
      S_BZW: begin
        if (sts_i.div_done) state_d = S_BR;
      end
      S_BR: begin
        cmd_o.op = OP_DIVR;
        state_d  = S_BRW;
      end
      S_BRW: begin
        if (sts_i.div_done) state_d = S_RZ;
      end
      S_RZ: begin
        cmd_o.iss = ISS_RZ;
        state_d   = S_P14;
      end
      S_P14: begin
        cmd_o.op = OP_P14;
        cnt_d    = '0;
        state_d  = S_MM;
      end
      S_MM: begin
        // i = cnt[5:4], j = cnt[3:2], k = cnt[1:0]
        cmd_o.iss    = ISS_MM;
        cmd_o.vaddr  = {cnt_q[5:4], cnt_q[1:0]};
        cmd_o.paddr  = {cnt_q[1:0], cnt_q[3:2]};
        cmd_o.povr   = 1'b1;
        cmd_o.mm_idx = cnt_q[5:2];
        cmd_o.first  = cnt_q[1:0] == 2'd0;
        cmd_o.last   = cnt_q[1:0] == 2'd3;
        cnt_d        = cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          cnt_d   = '0;
          state_d = S_MMD;
        end
      end
      S_MMD: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd2) begin
          cnt_d   = '0;
          pl_d    = PLANE_NEAR;
          state_d = S_PC;
        end
      end
      S_PC: begin
        cmd_o.iss    = ISS_PC;
        cmd_o.plane  = pl_q;
        cmd_o.second = cnt_q[0];
        cmd_o.k      = cnt_q[2:1];
        cmd_o.maddr  = cnt_q[0] ? {cnt_q[2:1], sel_col(pl_q)} : {cnt_q[2:1], COL_W};
        cnt_d        = cnt_q + 6'd1;
        if (cnt_q == 6'd7) begin
          cnt_d   = '0;
          state_d = S_PCD;
        end
      end
      S_PCD: begin
        state_d = S_SQ;
      end
      S_SQ: begin
        cmd_o.iss   = ISS_SQ;
        cmd_o.k     = cnt_q[1:0];
        cmd_o.first = cnt_q == 6'd0;
        cnt_d       = cnt_q + 6'd1;
        if (cnt_q == 6'd2) begin
          cnt_d   = '0;
          state_d = S_SQD;
        end
      end
      S_SQD: begin
        state_d = S_SQS;
      end
      S_SQS: begin
        cmd_o.op = OP_SQRT;
        state_d  = S_SQW;
      end
      S_SQW: begin
        kk_d = '0;
        if (sts_i.sqrt_done) state_d = S_DV;
      end
      S_DV: begin
        cmd_o.op    = OP_DIVP;
        cmd_o.plane = pl_q;
        cmd_o.k     = kk_q;
        state_d     = S_DVW;
      end
      S_DVW: begin
        if (sts_i.div_done) begin
          if (kk_q == 2'd3) begin
            if (pl_q == PLANE_BOTTOM) begin
              state_d = S_FIN;
            end else begin
              pl_d    = pl_q + 3'd1;
              cnt_d   = '0;
              state_d = S_PC;
            end
          end else begin
            kk_d    = kk_q + 2'd1;
            state_d = S_DV;
          end
        end
      end
      S_TI: begin
        cmd_o.iss   = ISS_TEST;
        cmd_o.plane = cnt_q[2:0];
        cnt_d       = cnt_q + 6'd1;
        if (cnt_q == 6'd5) begin
          cnt_d   = '0;
          state_d = S_TD;
        end
      end
      S_TD: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd2) begin
          cnt_d   = '0;
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        // hold the result until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.op    = OP_RESULT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      pl_q        <= '0;
      kk_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pl_q        <= pl_d;
      kk_q        <= kk_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

/* hw/rtl/frustum_box_culling_top.sv */
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid_i / in_stall_o  | kind, row, col, value, box min/max xyz
// out     | output    | out_valid_o / out_stall_i| visible, degenerate
// cfg     | input     | cfg_we_i                 | cfg_wdata_i (screen depth)
//
// One item at a time. A load writes its matrix entry and then shows its result; a box test
// runs six plane issues through three lane multipliers, a drain and then the result step.
// A build runs the divider 26 times and the square root six times.
// Reset clears control state and the plane store, so every box is visible.
// A stalled result holds in the output register while the next item is taken.
module frustum_box_culling_top
  import fbc_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [30:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          in_kind_i,
  input  logic [1:0]          in_row_i,
  input  logic [1:0]          in_col_i,
  input  logic signed [W-1:0] in_value_i,
  input  logic signed [W-1:0] in_min_x_i,
  input  logic signed [W-1:0] in_min_y_i,
  input  logic signed [W-1:0] in_min_z_i,
  input  logic signed [W-1:0] in_max_x_i,
  input  logic signed [W-1:0] in_max_y_i,
  input  logic signed [W-1:0] in_max_z_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                out_visible_o,
  output logic                out_degenerate_o
);

  logic [30:0] sd_q;
  cmd_t        cmd;
  sts_t        sts;

  // screen depth register: hold the last written value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sd_q <= SD_RESET;
    end else if (cfg_we_i) begin
      sd_q <= cfg_wdata_i;
    end
  end

  // sequence loads, builds and tests
  fbc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_kind_i   (in_kind_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // matrices, arithmetic units, planes and the result register
  fbc_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .sd_i         (sd_q),
    .kind_i       (in_kind_i),
    .row_i        (in_row_i),
    .col_i        (in_col_i),
    .value_i      (in_value_i),
    .min_x_i      (in_min_x_i),
    .min_y_i      (in_min_y_i),
    .min_z_i      (in_min_z_i),
    .max_x_i      (in_max_x_i),
    .max_y_i      (in_max_y_i),
    .max_z_i      (in_max_z_i),
    .visible_o    (out_visible_o),
    .degenerate_o (out_degenerate_o)
  );

endmodule
